[hdl/itm_pkg.sv]
// Shared constants and codes for the inverse thrust map.
`timescale 1ns / 1ps

package itm_pkg;

  // Default per-cell voltage window, unsigned Q6.10 volts.
  localparam int unsigned MinCellVoltDef = 3584;
  localparam int unsigned MaxCellVoltDef = 4301;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_QUAD   = 3'd0,
    REG_LIN    = 3'd1,
    REG_CONST  = 3'd2,
    REG_COMPEN = 3'd3,
    REG_SLOPE  = 3'd4,
    REG_OFFSET = 3'd5,
    REG_CELLS  = 3'd6
  } reg_idx_t;

  // Result status codes.
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NOROOT = 2'd1;
  localparam logic [1:0] STAT_SAT    = 2'd2;

endpackage

[hdl/inverse_thrust_map.sv]
// Inverse thrust map: voltage compensation, quadratic solve, pipelined.
//
//   channel   signals                                   direction
//   in        in_valid/in_ready, thrust_req, batt_volt  beat in
//   out       out_valid/out_ready, motor_cmd,           beat out
//             comp_skipped, map_status
//   cfg       psel/penable/pwrite/paddr/pwdata/prdata   register access
//
// One beat is accepted per cycle while the skid register is empty; each
// passes 77 register stages from input to output: six arithmetic stages, 34
// square root stages (two radicand bits each), one numerator stage, 35
// restoring divide stages and the output register.
// Synchronous reset clears all valid bits; there is no clearing pass.
// The whole pipeline holds while the skid register is occupied; in_ready is
// the inverse of that register's valid bit, so nothing is lost or repeated.
`timescale 1ns / 1ps

module inverse_thrust_map #(
  parameter int unsigned MIN_CELL_VOLT = itm_pkg::MinCellVoltDef,
  parameter int unsigned MAX_CELL_VOLT = itm_pkg::MaxCellVoltDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] thrust_req,
  input  logic [15:0] batt_volt,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] motor_cmd,
  output logic        comp_skipped,
  output logic [1:0]  map_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import itm_pkg::*;

  localparam int unsigned CellMax = (MIN_CELL_VOLT > MAX_CELL_VOLT) ?
                                    MIN_CELL_VOLT : MAX_CELL_VOLT;
  localparam int WinRaw = 4 + $clog2(CellMax + 1);
  localparam int WinW   = (WinRaw > 17) ? WinRaw : 17;
  localparam int SqSteps = 34;
  localparam int DvSteps = 35;

  typedef struct packed {
    logic               skip;
    logic               err;
    logic               a_neg;
    logic signed [31:0] b;
    logic [32:0]        den;
  } side_t;

  // Configuration registers.
  logic [31:0] quad_coeff, lin_coeff, const_coeff, ratio_slope, ratio_offset;
  logic        comp_enable;
  logic [3:0]  cell_count;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      quad_coeff   <= '0;
      lin_coeff    <= '0;
      const_coeff  <= '0;
      comp_enable  <= 1'b0;
      ratio_slope  <= '0;
      ratio_offset <= '0;
      cell_count   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_QUAD:   quad_coeff   <= pwdata;
        REG_LIN:    lin_coeff    <= pwdata;
        REG_CONST:  const_coeff  <= pwdata;
        REG_COMPEN: comp_enable  <= pwdata[0];
        REG_SLOPE:  ratio_slope  <= pwdata;
        REG_OFFSET: ratio_offset <= pwdata;
        REG_CELLS:  cell_count   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (cfg_idx)
      REG_QUAD:   prdata = quad_coeff;
      REG_LIN:    prdata = lin_coeff;
      REG_CONST:  prdata = const_coeff;
      REG_COMPEN: prdata = {31'd0, comp_enable};
      REG_SLOPE:  prdata = ratio_slope;
      REG_OFFSET: prdata = ratio_offset;
      REG_CELLS:  prdata = {28'd0, cell_count};
      default:    prdata = '0;
    endcase
  end

  // Pipeline advance: held only while the skid register is full.
  logic adv;
  logic skid_vld;
  assign adv      = !skid_vld;
  assign in_ready = adv;

  // Stage 1: slope times voltage, window check.
  logic [WinW-1:0]    win_lo, win_hi, v_ext;
  logic               s1_vld, s1_apply, s1_skip;
  logic signed [48:0] s1_prod;
  logic signed [31:0] s1_t;

  assign win_lo = WinW'(cell_count) * WinW'(MIN_CELL_VOLT);
  assign win_hi = WinW'(cell_count) * WinW'(MAX_CELL_VOLT);
  assign v_ext  = WinW'(batt_volt);

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else if (adv) s1_vld <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod  <= $signed(ratio_slope) * $signed({1'b0, batt_volt});
      s1_t     <= $signed(thrust_req);
      s1_apply <= comp_enable && (v_ext >= win_lo) && (v_ext <= win_hi);
      s1_skip  <= comp_enable && !((v_ext >= win_lo) && (v_ext <= win_hi));
    end
  end

  // Stage 2: ratio with offset, saturated to Q16.16.
  logic signed [40:0] ratio_sum;
  logic signed [31:0] s2_ratio, s2_t;
  logic               s2_vld, s2_apply, s2_skip;

  assign ratio_sum = {{2{s1_prod[48]}}, s1_prod[48:10]}
                   + {{9{ratio_offset[31]}}, ratio_offset};

  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else if (adv) s2_vld <= s1_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (ratio_sum > 41'sh0007FFFFFFF) s2_ratio <= 32'sh7FFFFFFF;
      else if (ratio_sum < -41'sh00080000000) s2_ratio <= 32'sh80000000;
      else s2_ratio <= ratio_sum[31:0];
      s2_t     <= s1_t;
      s2_apply <= s1_apply;
      s2_skip  <= s1_skip;
    end
  end

  // Stage 3: thrust times ratio.
  logic signed [63:0] s3_tr;
  logic signed [31:0] s3_t;
  logic               s3_vld, s3_apply, s3_skip;

  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else if (adv) s3_vld <= s2_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_tr    <= s2_t * s2_ratio;
      s3_t     <= s2_t;
      s3_apply <= s2_apply;
      s3_skip  <= s2_skip;
    end
  end

  // Stage 4: scaled thrust, then m = c - T'.
  logic signed [47:0] tr_sh;
  logic signed [31:0] t_use;
  logic signed [32:0] s4_m;
  logic               s4_vld, s4_skip;

  assign tr_sh = s3_tr[63:16];
  always_comb begin
    if (!s3_apply) t_use = s3_t;
    else if (tr_sh > 48'sh00007FFFFFFF) t_use = 32'sh7FFFFFFF;
    else if (tr_sh < -48'sh000080000000) t_use = 32'sh80000000;
    else t_use = tr_sh[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else if (adv) s4_vld <= s3_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_m    <= {const_coeff[31], const_coeff} - {t_use[31], t_use};
      s4_skip <= s3_skip;
    end
  end

  // Stage 5: |a|*|m| and b^2.
  logic [31:0] abs_a, abs_b;
  logic [32:0] abs_m;
  logic [63:0] s5_am, s5_bb;
  logic        s5_vld, s5_pos, s5_skip;

  assign abs_a = quad_coeff[31] ? (32'd0 - quad_coeff) : quad_coeff;
  assign abs_b = lin_coeff[31] ? (32'd0 - lin_coeff) : lin_coeff;
  assign abs_m = s4_m[32] ? (33'd0 - s4_m) : s4_m;

  always_ff @(posedge clk) begin
    if (rst) s5_vld <= 1'b0;
    else if (adv) s5_vld <= s4_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_am   <= 64'({32'd0, abs_a} * {31'd0, abs_m});
      s5_bb   <= {32'd0, abs_b} * {32'd0, abs_b};
      s5_pos  <= (s4_m != '0) && (quad_coeff[31] == s4_m[32]);
      s5_skip <= s4_skip;
    end
  end

  // Stage 6: discriminant in Q32.32.
  logic [67:0] p4, bb_ext;
  assign p4     = {2'b00, s5_am, 2'b00};
  assign bb_ext = {4'd0, s5_bb};

  logic        sq_vld  [0:SqSteps];
  logic [67:0] sq_rad  [0:SqSteps];
  logic [35:0] sq_rem  [0:SqSteps];
  logic [33:0] sq_root [0:SqSteps];
  side_t       sq_side [0:SqSteps];

  always_ff @(posedge clk) begin
    if (rst) sq_vld[0] <= 1'b0;
    else if (adv) sq_vld[0] <= s5_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rad[0]        <= (s5_pos && (p4 > bb_ext)) ? '0 :
                          (s5_pos ? (bb_ext - p4) : (bb_ext + p4));
      sq_rem[0]        <= '0;
      sq_root[0]       <= '0;
      sq_side[0].skip  <= s5_skip;
      sq_side[0].err   <= (quad_coeff == '0) || (s5_pos && (p4 > bb_ext));
      sq_side[0].a_neg <= quad_coeff[31];
      sq_side[0].b     <= lin_coeff;
      sq_side[0].den   <= {abs_a, 1'b0};
    end
  end

  // Square root: one root bit per stage.
  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    logic [35:0] rem_sh, trial;
    logic        fit;
    assign rem_sh = {sq_rem[k][33:0], sq_rad[k][67:66]};
    assign trial  = {sq_root[k], 2'b01};
    assign fit    = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) sq_vld[k+1] <= 1'b0;
      else if (adv) sq_vld[k+1] <= sq_vld[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rad[k+1]  <= {sq_rad[k][65:0], 2'b00};
        sq_rem[k+1]  <= fit ? (rem_sh - trial) : rem_sh;
        sq_root[k+1] <= {sq_root[k][32:0], fit};
        sq_side[k+1] <= sq_side[k];
      end
    end
  end

  // Numerator s - b, its magnitude and the quotient sign.
  logic signed [35:0] num;
  assign num = $signed({2'b00, sq_root[SqSteps]})
             - {{4{sq_side[SqSteps].b[31]}}, sq_side[SqSteps].b};

  logic        dv_vld  [0:DvSteps];
  logic [32:0] dv_rem  [0:DvSteps];
  logic [34:0] dv_q    [0:DvSteps];
  logic        dv_qneg [0:DvSteps];
  side_t       dv_side [0:DvSteps];

  always_ff @(posedge clk) begin
    if (rst) dv_vld[0] <= 1'b0;
    else if (adv) dv_vld[0] <= sq_vld[SqSteps];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0]  <= '0;
      dv_q[0]    <= num[35] ? 35'(36'd0 - num) : num[34:0];
      dv_qneg[0] <= num[35] ^ sq_side[SqSteps].a_neg;
      dv_side[0] <= sq_side[SqSteps];
    end
  end

  // Restoring divide: one quotient bit per stage.
  for (genvar k = 0; k < DvSteps; k++) begin : g_div
    logic [33:0] part;
    logic        ge;
    assign part = {dv_rem[k], dv_q[k][34]};
    assign ge   = part >= {1'b0, dv_side[k].den};

    always_ff @(posedge clk) begin
      if (rst) dv_vld[k+1] <= 1'b0;
      else if (adv) dv_vld[k+1] <= dv_vld[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[k+1]  <= ge ? 33'(part - {1'b0, dv_side[k].den}) : part[32:0];
        dv_q[k+1]    <= {dv_q[k][33:0], ge};
        dv_qneg[k+1] <= dv_qneg[k];
        dv_side[k+1] <= dv_side[k];
      end
    end
  end

  // Final classification of the root.
  logic [15:0] res_cmd;
  logic [1:0]  res_stat;
  logic        res_skip, res_vld;
  logic [34:0] qm;

  assign qm       = dv_q[DvSteps];
  assign res_skip = dv_side[DvSteps].skip;
  assign res_vld  = dv_vld[DvSteps];

  always_comb begin
    if (dv_side[DvSteps].err) begin
      res_cmd  = '0;
      res_stat = STAT_NOROOT;
    end else if (dv_qneg[DvSteps] && (qm != '0)) begin
      res_cmd  = '0;
      res_stat = STAT_SAT;
    end else if (qm[34:16] != '0) begin
      res_cmd  = 16'hFFFF;
      res_stat = STAT_SAT;
    end else begin
      res_cmd  = qm[15:0];
      res_stat = STAT_OK;
    end
  end

  // Output register with skid register behind it.
  logic [15:0] skid_cmd;
  logic [1:0]  skid_stat;
  logic        skid_skip;
  logic        take_new, out_free;

  assign out_free = !out_valid || out_ready;
  assign take_new = adv && res_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else begin
      if (skid_vld) begin
        if (out_ready) begin
          out_valid <= 1'b1;
          skid_vld  <= 1'b0;
        end
      end else if (take_new) begin
        if (out_free) out_valid <= 1'b1;
        else skid_vld <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (out_ready) begin
        motor_cmd    <= skid_cmd;
        map_status   <= skid_stat;
        comp_skipped <= skid_skip;
      end
    end else if (take_new) begin
      if (out_free) begin
        motor_cmd    <= res_cmd;
        map_status   <= res_stat;
        comp_skipped <= res_skip;
      end else begin
        skid_cmd  <= res_cmd;
        skid_stat <= res_stat;
        skid_skip <= res_skip;
      end
    end
  end

endmodule

[hdl/itm_checker.sv]
// Port-level checks for the inverse thrust map, bound to the top level.
`timescale 1ns / 1ps

module itm_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] motor_cmd,
  input logic        comp_skipped,
  input logic [1:0]  map_status,
  input logic        pready
);
  import itm_pkg::*;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(motor_cmd)
      && $stable(map_status) && $stable(comp_skipped))
    else $error("result beat changed while stalled");

  // A missing root always drives a zero command.
  a_noroot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (map_status == STAT_NOROOT) |-> motor_cmd == '0)
    else $error("no-root result with nonzero command");

  // Saturation lands on one of the two range ends.
  a_sat_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && (map_status == STAT_SAT) |->
      (motor_cmd == 16'h0000) || (motor_cmd == 16'hFFFF))
    else $error("saturated command not at a range end");

  // No result appears in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("register port stalled");

endmodule

bind inverse_thrust_map itm_checker u_itm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .motor_cmd    (motor_cmd),
  .comp_skipped (comp_skipped),
  .map_status   (map_status),
  .pready       (pready)
);
